// ----- rtl/core/edmm_pkg.sv -----
// ----------------------------------------------------------------------------
// edmm_pkg: shared types and constants of the event rule matcher
// Function codes, rule row layout, flag bits and sequencer states.
// ----------------------------------------------------------------------------
package edmm_pkg;

  localparam int ROWS_DEF      = 8;
  localparam int ADDR_ROWS     = 8;
  localparam int ROW_BYTES     = 8;
  localparam int ROW_W         = ROW_BYTES * 8;
  localparam int CLASS_W       = 9;

  localparam logic [7:0] FLAG_ENABLED = 8'h80;
  localparam logic [7:0] FLAG_ORIGIN  = 8'h40;
  localparam logic [7:0] FLAG_ZONE    = 8'h10;
  localparam logic [7:0] FLAG_MASK8   = 8'h02;
  localparam logic [7:0] FLAG_FILT8   = 8'h01;

  localparam logic [7:0] READ_ERR_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_EVENT = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // byte 0 (origin) sits in the low bits of the stored row word
  typedef struct packed {
    logic [7:0] param;
    logic [7:0] action;
    logic [7:0] tfilt;
    logic [7:0] tmask;
    logic [7:0] cfilt;
    logic [7:0] cmask;
    logic [7:0] flags;
    logic [7:0] origin;
  } rule_row_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [7:0]         typ;
    logic [7:0]         orig;
    logic               zone_ok;
  } ev_key_t;

endpackage

// ----- rtl/core/edmm_ram.sv -----
// ----------------------------------------------------------------------------
// edmm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module edmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/edmm_row_cmp.sv -----
// ----------------------------------------------------------------------------
// edmm_row_cmp: rule row compare unit
// Checks one rule row against the held event: enable, origin, zone, masked
// nine-bit class and masked type.
// ----------------------------------------------------------------------------
module edmm_row_cmp (
  input  edmm_pkg::rule_row_t row,
  input  edmm_pkg::ev_key_t   key,
  output logic                hit
);

  logic [edmm_pkg::CLASS_W-1:0] cmask;
  logic [edmm_pkg::CLASS_W-1:0] cfilt;
  logic                         en_ok;
  logic                         orig_ok;
  logic                         zone_ok;
  logic                         cls_ok;
  logic                         typ_ok;

  assign cmask   = {(|(row.flags & edmm_pkg::FLAG_MASK8)), row.cmask};
  assign cfilt   = {(|(row.flags & edmm_pkg::FLAG_FILT8)), row.cfilt};
  assign en_ok   = |(row.flags & edmm_pkg::FLAG_ENABLED);
  assign orig_ok = !(|(row.flags & edmm_pkg::FLAG_ORIGIN)) || (key.orig == row.origin);
  assign zone_ok = !(|(row.flags & edmm_pkg::FLAG_ZONE)) || key.zone_ok;
  assign cls_ok  = ((key.cls ^ cfilt) & cmask) == '0;
  assign typ_ok  = ((key.typ ^ row.tfilt) & row.tmask) == '0;
  assign hit     = en_ok && orig_ok && zone_ok && cls_ok && typ_ok;

endmodule

// ----- rtl/core/event_decision_matrix_match_unit.sv -----
// ----------------------------------------------------------------------------
// event_decision_matrix_match_unit: masked rule table matcher
// Holds a table of 8-byte rule rows and matches events against them.
//
// Input: pulse start with the in_ fields while busy is low; the beat is taken
// at that edge. in_func selects event match, table byte write or byte read.
// Results: out_valid marks one beat per cycle; out_last flags the final beat
// of an item. The receiver cannot stall, so results are never held back.
// Write and read: one beat. An in-table access reads the row, then writes
// back or selects the byte; an access beyond the table answers from idle.
// Event: the row compare unit visits one row per cycle over min(ROWS,8)
// rows, then flushes; each matching row gives one beat, rows in order.
// Class 0 and func 3 give no beat and are dropped in the accept cycle.
// Configuration: cfg_wr_en writes node_zone; write only while not busy.
// Reset: node_zone and all row valid bits clear, so every row reads zero
// and is disabled; no clearing pass is needed.
// ----------------------------------------------------------------------------
module event_decision_matrix_match_unit #(
  parameter int ROWS = edmm_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [5:0] in_table_addr,
  input  logic [7:0] in_table_byte,
  input  logic [8:0] in_event_class,
  input  logic [7:0] in_event_type,
  input  logic [7:0] in_origin_addr,
  input  logic [7:0] in_event_zone,
  input  logic [7:0] in_event_arg,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_valid,
  output logic       out_matched,
  output logic [2:0] out_row_index,
  output logic [7:0] out_action_code,
  output logic [7:0] out_action_param,
  output logic [7:0] out_forwarded_arg,
  output logic [7:0] out_read_data,
  output logic       out_last
);

  localparam int EFF_ROWS = (ROWS < edmm_pkg::ADDR_ROWS) ? ROWS : edmm_pkg::ADDR_ROWS;
  localparam int AW       = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(EFF_ROWS - 1);
  localparam int RW       = edmm_pkg::ROW_W;

  edmm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [EFF_ROWS-1:0] row_vld_r, row_vld_nxt;
  logic [7:0]       node_zone_r;

  logic [5:0]       addr_r;
  logic [7:0]       byte_r;
  logic [8:0]       cls_r;
  logic [7:0]       typ_r;
  logic [7:0]       orig_r;
  logic [7:0]       zone_r;
  logic [7:0]       arg_r;
  logic             rd_vld_r;

  logic             pend_vld_r, pend_vld_nxt;
  logic [2:0]       pend_row_r, pend_row_nxt;
  logic [7:0]       pend_act_r, pend_act_nxt;
  logic [7:0]       pend_par_r, pend_par_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic [2:0]       out_row_index_r, out_row_index_nxt;
  logic [7:0]       out_action_code_r, out_action_code_nxt;
  logic [7:0]       out_action_param_r, out_action_param_nxt;
  logic [7:0]       out_forwarded_arg_r, out_forwarded_arg_nxt;
  logic [7:0]       out_read_data_r, out_read_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             in_rng;
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [AW-1:0]    addr_row;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;
  logic [RW-1:0]    row_data;
  edmm_pkg::rule_row_t row_s;
  edmm_pkg::ev_key_t   key_s;
  logic             hit;

  assign busy     = (state_r != edmm_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_rng   = (32'(in_table_addr[5:3]) < EFF_ROWS);
  assign addr_row = AW'(addr_r[5:3]);
  assign row_data = ram_rdata & {RW{rd_vld_r}};
  assign row_s    = edmm_pkg::rule_row_t'(row_data);
  assign key_s    = '{cls: cls_r, typ: typ_r, orig: orig_r,
                      zone_ok: (zone_r == node_zone_r)};

  edmm_ram #(
    .WIDTH (RW),
    .DEPTH (EFF_ROWS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_row),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  edmm_row_cmp u_cmp (
    .row (row_s),
    .key (key_s),
    .hit (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edmm_pkg::ST_IDLE;
      cnt_r       <= '0;
      row_vld_r   <= '0;
      node_zone_r <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_vld_r   <= row_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_zone_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_table_addr;
      byte_r <= in_table_byte;
      cls_r  <= in_event_class;
      typ_r  <= in_event_type;
      orig_r <= in_origin_addr;
      zone_r <= in_event_zone;
      arg_r  <= in_event_arg;
    end
    rd_vld_r            <= row_vld_r[ram_raddr];
    pend_row_r          <= pend_row_nxt;
    pend_act_r          <= pend_act_nxt;
    pend_par_r          <= pend_par_nxt;
    out_matched_r       <= out_matched_nxt;
    out_row_index_r     <= out_row_index_nxt;
    out_action_code_r   <= out_action_code_nxt;
    out_action_param_r  <= out_action_param_nxt;
    out_forwarded_arg_r <= out_forwarded_arg_nxt;
    out_read_data_r     <= out_read_data_nxt;
    out_last_r          <= out_last_nxt;
  end

  always_comb begin
    state_nxt             = state_r;
    cnt_nxt               = cnt_r;
    row_vld_nxt           = row_vld_r;
    pend_vld_nxt          = pend_vld_r;
    pend_row_nxt          = pend_row_r;
    pend_act_nxt          = pend_act_r;
    pend_par_nxt          = pend_par_r;
    ram_we                = 1'b0;
    ram_raddr             = addr_row;
    ram_wdata             = row_data;
    out_valid_nxt         = 1'b0;
    out_matched_nxt       = 1'b0;
    out_row_index_nxt     = '0;
    out_action_code_nxt   = '0;
    out_action_param_nxt  = '0;
    out_forwarded_arg_nxt = '0;
    out_read_data_nxt     = '0;
    out_last_nxt          = 1'b0;
    unique case (state_r)
      edmm_pkg::ST_IDLE: begin
        ram_raddr = AW'(in_table_addr[5:3]);
        if (start) begin
          unique case (edmm_pkg::func_t'(in_func))
            edmm_pkg::FUNC_WRITE: begin
              if (in_rng) begin
                state_nxt = edmm_pkg::ST_WR;
              end else begin
                out_valid_nxt     = 1'b1;
                out_read_data_nxt = ~in_table_byte;
                out_last_nxt      = 1'b1;
              end
            end
            edmm_pkg::FUNC_READ: begin
              if (in_rng) begin
                state_nxt = edmm_pkg::ST_RD;
              end else begin
                out_valid_nxt     = 1'b1;
                out_read_data_nxt = edmm_pkg::READ_ERR_BYTE;
                out_last_nxt      = 1'b1;
              end
            end
            edmm_pkg::FUNC_EVENT: begin
              if (in_event_class != '0) begin
                ram_raddr    = '0;
                cnt_nxt      = '0;
                pend_vld_nxt = 1'b0;
                state_nxt    = edmm_pkg::ST_SCAN;
              end
            end
            edmm_pkg::FUNC_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      edmm_pkg::ST_WR: begin
        ram_we                          = 1'b1;
        ram_wdata[addr_r[2:0]*8 +: 8]   = byte_r;
        row_vld_nxt[addr_row]           = 1'b1;
        out_valid_nxt                   = 1'b1;
        out_read_data_nxt               = byte_r;
        out_last_nxt                    = 1'b1;
        state_nxt                       = edmm_pkg::ST_IDLE;
      end
      edmm_pkg::ST_RD: begin
        out_valid_nxt     = 1'b1;
        out_read_data_nxt = row_data[addr_r[2:0]*8 +: 8];
        out_last_nxt      = 1'b1;
        state_nxt         = edmm_pkg::ST_IDLE;
      end
      edmm_pkg::ST_SCAN: begin
        ram_raddr = AW'(cnt_r + 1'b1);
        if (hit) begin
          // release the older hit, hold the new one until the next hit or end
          if (pend_vld_r) begin
            out_valid_nxt         = 1'b1;
            out_matched_nxt       = 1'b1;
            out_row_index_nxt     = pend_row_r;
            out_action_code_nxt   = pend_act_r;
            out_action_param_nxt  = pend_par_r;
            out_forwarded_arg_nxt = arg_r;
          end
          pend_vld_nxt = 1'b1;
          pend_row_nxt = 3'(cnt_r);
          pend_act_nxt = row_s.action;
          pend_par_nxt = row_s.param;
        end
        if (cnt_r == LAST_ROW) begin
          state_nxt = edmm_pkg::ST_FLUSH;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      edmm_pkg::ST_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt         = 1'b1;
          out_matched_nxt       = 1'b1;
          out_row_index_nxt     = pend_row_r;
          out_action_code_nxt   = pend_act_r;
          out_action_param_nxt  = pend_par_r;
          out_forwarded_arg_nxt = arg_r;
          out_last_nxt          = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = edmm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = edmm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_row_index     = out_row_index_r;
  assign out_action_code   = out_action_code_r;
  assign out_action_param  = out_action_param_r;
  assign out_forwarded_arg = out_forwarded_arg_r;
  assign out_read_data     = out_read_data_r;
  assign out_last          = out_last_r;

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edmm_pkg::ST_SCAN) |=>
      (state_r == edmm_pkg::ST_SCAN || state_r == edmm_pkg::ST_FLUSH))
    else $error("scan left to an unexpected state");

  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edmm_pkg::ST_FLUSH) |=> (state_r == edmm_pkg::ST_IDLE && !pend_vld_r))
    else $error("flush did not return to idle with pending hit cleared");

  a_access_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_matched_r) |-> (out_last_r && out_row_index_r == '0))
    else $error("table access beat not final");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edmm_pkg::ST_IDLE && !start) |=> !out_valid_r)
    else $error("beat emitted without an item");

  a_match_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> (out_read_data_r == '0))
    else $error("match beat carries read data");

endmodule

// ----- bench/event_decision_matrix_match_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_decision_matrix_match_unit_tb: rule table matcher testbench
// Drives table byte writes, reads and events into the matcher. A scoreboard
// keeps its own copy of the rule table and zone, predicts the beats of each
// accepted item and checks every out_valid beat field by field. Directed
// items come first, then random phases with different zones and idling.
// ----------------------------------------------------------------------------
module event_decision_matrix_match_unit_tb;

  localparam int ROWS         = edmm_pkg::ROWS_DEF;
  localparam int TABLE_BYTES  = ROWS * edmm_pkg::ROW_BYTES;
  localparam int SCAN_CYCLES  = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 17;

  localparam int POS_ORIGIN = 0;
  localparam int POS_FLAGS  = 1;
  localparam int POS_CMASK  = 2;
  localparam int POS_CFILT  = 3;
  localparam int POS_TMASK  = 4;
  localparam int POS_TFILT  = 5;
  localparam int POS_ACTION = 6;
  localparam int POS_PARAM  = 7;

  typedef struct {
    edmm_pkg::func_t func;
    logic [5:0]      addr;
    logic [7:0]      wbyte;
    logic [8:0]      cls;
    logic [7:0]      typ;
    logic [7:0]      orig;
    logic [7:0]      zone;
    logic [7:0]      arg;
  } item_t;

  typedef struct {
    logic       matched;
    logic [2:0] row;
    logic [7:0] action;
    logic [7:0] param;
    logic [7:0] arg;
    logic [7:0] rdata;
    logic       last;
  } beat_t;

  class match_scoreboard;
    logic [7:0] rule_bytes [TABLE_BYTES];
    logic [7:0] zone_reg;
    beat_t      expected_beats [$];
    int         errors;

    function new();
      foreach (rule_bytes[i]) rule_bytes[i] = 8'h00;
      zone_reg = 8'h00;
      errors   = 0;
    endfunction

    function void set_zone(logic [7:0] v);
      zone_reg = v;
    endfunction

    function int waiting();
      return expected_beats.size();
    endfunction

    function logic [8:0] rule_cmask9(int r);
      return {((rule_bytes[r*edmm_pkg::ROW_BYTES+POS_FLAGS] & edmm_pkg::FLAG_MASK8) != 0),
              rule_bytes[r*edmm_pkg::ROW_BYTES+POS_CMASK]};
    endfunction

    function logic [8:0] rule_cfilt9(int r);
      return {((rule_bytes[r*edmm_pkg::ROW_BYTES+POS_FLAGS] & edmm_pkg::FLAG_FILT8) != 0),
              rule_bytes[r*edmm_pkg::ROW_BYTES+POS_CFILT]};
    endfunction

    function void note_item(item_t it);
      beat_t      b;
      int         hits [$];
      int         base;
      logic [7:0] flags;
      b = '{1'b0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
      case (it.func)
        edmm_pkg::FUNC_WRITE: begin
          if (it.addr < TABLE_BYTES) begin
            rule_bytes[it.addr] = it.wbyte;
            b.rdata = it.wbyte;
          end else begin
            b.rdata = ~it.wbyte;
          end
          expected_beats.push_back(b);
        end
        edmm_pkg::FUNC_READ: begin
          b.rdata = (it.addr < TABLE_BYTES) ? rule_bytes[it.addr] : edmm_pkg::READ_ERR_BYTE;
          expected_beats.push_back(b);
        end
        edmm_pkg::FUNC_EVENT: begin
          if (it.cls != 0) begin
            for (int r = 0; r < ROWS; r++) begin
              base  = r * edmm_pkg::ROW_BYTES;
              flags = rule_bytes[base+POS_FLAGS];
              if ((flags & edmm_pkg::FLAG_ENABLED) == 0) continue;
              if ((flags & edmm_pkg::FLAG_ORIGIN) != 0 && it.orig != rule_bytes[base+POS_ORIGIN])
                continue;
              if ((flags & edmm_pkg::FLAG_ZONE) != 0 && it.zone != zone_reg) continue;
              if (((it.cls ^ rule_cfilt9(r)) & rule_cmask9(r)) != 0) continue;
              if (((it.typ ^ rule_bytes[base+POS_TFILT]) & rule_bytes[base+POS_TMASK]) != 0)
                continue;
              hits.push_back(r);
            end
            foreach (hits[k]) begin
              base     = hits[k] * edmm_pkg::ROW_BYTES;
              b.matched = 1'b1;
              b.row    = 3'(hits[k]);
              b.action = rule_bytes[base+POS_ACTION];
              b.param  = rule_bytes[base+POS_PARAM];
              b.arg    = it.arg;
              b.rdata  = 8'h00;
              b.last   = (k == hits.size() - 1);
              expected_beats.push_back(b);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat with nothing expected, row %0d read_data %02h",
                         got.row, got.rdata));
        return;
      end
      want = expected_beats.pop_front();
      if (got.matched !== want.matched)
        report($sformatf("matched %b, want %b", got.matched, want.matched));
      if (got.row !== want.row)
        report($sformatf("row_index %0d, want %0d", got.row, want.row));
      if (got.action !== want.action)
        report($sformatf("action_code %02h, want %02h", got.action, want.action));
      if (got.param !== want.param)
        report($sformatf("action_param %02h, want %02h", got.param, want.param));
      if (got.arg !== want.arg)
        report($sformatf("forwarded_arg %02h, want %02h", got.arg, want.arg));
      if (got.rdata !== want.rdata)
        report($sformatf("read_data %02h, want %02h", got.rdata, want.rdata));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_func;
  logic [5:0] in_table_addr;
  logic [7:0] in_table_byte;
  logic [8:0] in_event_class;
  logic [7:0] in_event_type;
  logic [7:0] in_origin_addr;
  logic [7:0] in_event_zone;
  logic [7:0] in_event_arg;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       out_valid;
  logic       out_matched;
  logic [2:0] out_row_index;
  logic [7:0] out_action_code;
  logic [7:0] out_action_param;
  logic [7:0] out_forwarded_arg;
  logic [7:0] out_read_data;
  logic       out_last;

  match_scoreboard sb;
  int              cycle_cnt;

  event_decision_matrix_match_unit #(.ROWS(ROWS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_table_addr    (in_table_addr),
    .in_table_byte    (in_table_byte),
    .in_event_class   (in_event_class),
    .in_event_type    (in_event_type),
    .in_origin_addr   (in_origin_addr),
    .in_event_zone    (in_event_zone),
    .in_event_arg     (in_event_arg),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_matched      (out_matched),
    .out_row_index    (out_row_index),
    .out_action_code  (out_action_code),
    .out_action_param (out_action_param),
    .out_forwarded_arg(out_forwarded_arg),
    .out_read_data    (out_read_data),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_beat('{out_matched, out_row_index, out_action_code, out_action_param,
                        out_forwarded_arg, out_read_data, out_last});
      if (start && !busy)
        sb.note_item('{edmm_pkg::func_t'(in_func), in_table_addr, in_table_byte,
                       in_event_class, in_event_type, in_origin_addr, in_event_zone,
                       in_event_arg});
      if (cfg_wr_en) sb.set_zone(cfg_wr_data);
    end
  end

  task automatic put_item(item_t it);
    start          <= 1'b1;
    in_func        <= it.func;
    in_table_addr  <= it.addr;
    in_table_byte  <= it.wbyte;
    in_event_class <= it.cls;
    in_event_type  <= it.typ;
    in_origin_addr <= it.orig;
    in_event_zone  <= it.zone;
    in_event_arg   <= it.arg;
    do @(posedge clk); while (busy);
  endtask

  task automatic directed(edmm_pkg::func_t f, int addr, int wbyte, int cls, int typ,
                          int orig, int zone, int arg);
    item_t it;
    it = '{f, 6'(addr), 8'(wbyte), 9'(cls), 8'(typ), 8'(orig), 8'(zone), 8'(arg)};
    @(negedge clk);
    put_item(it);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_zone(logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic item_t next_stimulus(int fill_addr);
    item_t it;
    int    pick;
    int    r;
    it.func  = edmm_pkg::FUNC_EVENT;
    it.addr  = 6'($urandom);
    it.wbyte = 8'($urandom);
    it.cls   = 9'($urandom);
    it.typ   = 8'($urandom);
    it.orig  = 8'($urandom);
    it.zone  = 8'($urandom);
    it.arg   = 8'($urandom);
    pick = (fill_addr >= 0) ? 0 : $urandom_range(99);
    if (pick < 30) begin
      it.func = edmm_pkg::FUNC_WRITE;
      if (fill_addr >= 0) it.addr = 6'(fill_addr);
      case (int'(it.addr[2:0]))
        POS_FLAGS: it.wbyte[7] = ($urandom_range(9) != 0);
        POS_CMASK, POS_TMASK: it.wbyte = it.wbyte & 8'($urandom);
        default: ;
      endcase
    end else if (pick < 42) begin
      it.func = edmm_pkg::FUNC_READ;
    end else if (pick < 88) begin
      r = $urandom_range(ROWS - 1);
      it.cls = sb.rule_cfilt9(r) ^ (it.cls & ~sb.rule_cmask9(r));
      it.typ = sb.rule_bytes[r*edmm_pkg::ROW_BYTES+POS_TFILT]
               ^ (it.typ & ~sb.rule_bytes[r*edmm_pkg::ROW_BYTES+POS_TMASK]);
      if ($urandom_range(3) != 0) it.orig = sb.rule_bytes[r*edmm_pkg::ROW_BYTES+POS_ORIGIN];
      if ($urandom_range(3) != 0) it.zone = sb.zone_reg;
    end else if (pick < 95) begin
      if ($urandom_range(3) == 0) it.cls = '0;
    end else begin
      it.func = edmm_pkg::FUNC_NONE;
    end
    return it;
  endfunction

  initial begin
    item_t      it;
    int         idle_pct [4];
    logic [7:0] zones [4];
    int         row;
    int         n;
    idle_pct = '{0, 85, 30, 0};
    zones    = '{8'hFF, 8'h00, 8'($urandom), 8'h80};
    sb = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = edmm_pkg::FUNC_EVENT;
    in_table_addr  = '0;
    in_table_byte  = '0;
    in_event_class = '0;
    in_event_type  = '0;
    in_origin_addr = '0;
    in_event_zone  = '0;
    in_event_arg   = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed(edmm_pkg::FUNC_READ,  0,  0, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_EVENT, 0,  0, 'h1FF, 'hFF, 'hFF, 'hFF, 'hFF);
    directed(edmm_pkg::FUNC_WRITE, 0, 'hFF, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 1, 'hD3, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 2, 'hFF, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 3, 'h00, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 4, 'hFF, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 5, 'hAA, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 6, 'hFF, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 7, 'h00, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h100, 'hAA, 'hFF, 'h00, 'h55);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h100, 'hAA, 'h00, 'h00, 'h55);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h100, 'hAA, 'hFF, 'h01, 'h55);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h100, 'hAB, 'hFF, 'h00, 'h55);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 0, 'hAA, 'hFF, 'h00, 'h55);
    directed(edmm_pkg::FUNC_NONE, 63, 'hFF, 'h1FF, 'hFF, 'hFF, 'hFF, 'hFF);
    directed(edmm_pkg::FUNC_WRITE, 57, 'h80, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h100, 'hAA, 'hFF, 'h00, 'hFF);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h001, 'h00, 'h00, 'hFF, 'h00);
    directed(edmm_pkg::FUNC_READ, 63, 0, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_READ,  7, 0, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_READ,  6, 0, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_WRITE, 63, 'hFF, 0, 0, 0, 0, 0);
    directed(edmm_pkg::FUNC_EVENT, 0, 0, 'h0FF, 'h3C, 'h12, 'h34, 'hA5);

    for (int ph = 0; ph < 4; ph++) begin
      write_zone(zones[ph]);
      row = $urandom_range(ROWS - 1);
      for (int k = 0; k < edmm_pkg::ROW_BYTES; k++) begin
        idle_gap(idle_pct[ph]);
        @(negedge clk);
        put_item(next_stimulus(row * edmm_pkg::ROW_BYTES + k));
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        idle_gap(idle_pct[ph]);
        @(negedge clk);
        it = next_stimulus(-1);
        put_item(it);
        if (!(it.func == edmm_pkg::FUNC_NONE ||
              (it.func == edmm_pkg::FUNC_EVENT && it.cls == 0))) n++;
        if ($urandom_range(19) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
